>>> rtl/core/spq_pkg.sv
package spq_pkg;

    // Request kinds carried in s_tuser
    localparam logic MODE_ENQUEUE = 1'b0;
    localparam logic MODE_DEQUEUE = 1'b1;

    // Result status codes carried in m_tuser
    typedef logic [1:0] status_t;
    localparam status_t STATUS_ENQUEUED = 2'd0;
    localparam status_t STATUS_DEQUEUED = 2'd1;
    localparam status_t STATUS_EMPTY    = 2'd2;
    localparam status_t STATUS_FULL     = 2'd3;

    localparam int PRIO_W   = 8;
    localparam int AGE_W    = 8;
    localparam int HANDLE_W = 16;
    localparam int FILL_W   = 5;
    localparam int IN_W     = PRIO_W + AGE_W + HANDLE_W;
    localparam int OUT_W    = 40;

    typedef enum logic
    {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed
    {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

>>> rtl/core/spq_ctrl.sv
module spq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output spq_pkg::ctrl_cmd_t cmd
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            accept;

    assign s_tready = (state_reg == spq_pkg::S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = spq_pkg::S_EXEC;
                end
            end
            spq_pkg::S_EXEC:
            begin
                state_next = spq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                cmd.capture = accept;
            end
            spq_pkg::S_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            default:
            begin
                cmd.capture = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/spq_datapath.sv
module spq_datapath
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  spq_pkg::ctrl_cmd_t         cmd,
    input  logic [spq_pkg::IN_W-1:0]   s_tdata,
    input  logic                       s_tuser,
    output logic [spq_pkg::OUT_W-1:0]  m_tdata,
    output logic [1:0]                 m_tuser
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // captured request
    logic                          mode_reg;
    logic [spq_pkg::PRIO_W-1:0]    prio_reg;
    logic [spq_pkg::AGE_W-1:0]     age_reg;
    logic [spq_pkg::HANDLE_W-1:0]  handle_reg;

    // sorted slots, head at index 0
    logic [spq_pkg::PRIO_W-1:0]    slot_prio_reg   [QUEUE_DEPTH];
    logic [spq_pkg::AGE_W-1:0]     slot_age_reg    [QUEUE_DEPTH];
    logic [spq_pkg::HANDLE_W-1:0]  slot_handle_reg [QUEUE_DEPTH];
    logic [spq_pkg::PRIO_W-1:0]    slot_prio_next   [QUEUE_DEPTH];
    logic [spq_pkg::AGE_W-1:0]     slot_age_next    [QUEUE_DEPTH];
    logic [spq_pkg::HANDLE_W-1:0]  slot_handle_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]        stay;

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          full;
    logic                          empty;
    logic                          do_enq;
    logic                          do_deq;
    logic [31:0]                   count_ext;

    // result registers
    spq_pkg::status_t              status_reg;
    spq_pkg::status_t              status_next;
    logic [spq_pkg::AGE_W-1:0]     out_age_reg;
    logic [spq_pkg::HANDLE_W-1:0]  out_handle_reg;
    logic [spq_pkg::PRIO_W-1:0]    out_prio_reg;
    logic [spq_pkg::FILL_W-1:0]    fill_reg;

    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_enq = (mode_reg == spq_pkg::MODE_ENQUEUE) && !full;
    assign do_deq = (mode_reg == spq_pkg::MODE_DEQUEUE) && !empty;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= s_tuser;
            prio_reg   <= s_tdata[spq_pkg::PRIO_W-1:0];
            age_reg    <= s_tdata[spq_pkg::PRIO_W +: spq_pkg::AGE_W];
            handle_reg <= s_tdata[spq_pkg::PRIO_W + spq_pkg::AGE_W +: spq_pkg::HANDLE_W];
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_slot
            // stored entry at or ahead of the new one keeps its place
            assign stay[gi] = (CNT_W'(gi) < count_reg) && (slot_prio_reg[gi] <= prio_reg);

            always_comb
            begin
                slot_prio_next[gi]   = slot_prio_reg[gi];
                slot_age_next[gi]    = slot_age_reg[gi];
                slot_handle_next[gi] = slot_handle_reg[gi];
                if (do_enq && !stay[gi])
                begin
                    if (gi == 0 || stay[(gi == 0) ? 0 : gi - 1])
                    begin
                        slot_prio_next[gi]   = prio_reg;
                        slot_age_next[gi]    = age_reg;
                        slot_handle_next[gi] = handle_reg;
                    end
                    else
                    begin
                        slot_prio_next[gi]   = slot_prio_reg[(gi == 0) ? 0 : gi - 1];
                        slot_age_next[gi]    = slot_age_reg[(gi == 0) ? 0 : gi - 1];
                        slot_handle_next[gi] = slot_handle_reg[(gi == 0) ? 0 : gi - 1];
                    end
                end
                else if (do_deq && gi < QUEUE_DEPTH - 1)
                begin
                    slot_prio_next[gi]   = slot_prio_reg[(gi < QUEUE_DEPTH - 1) ? gi + 1 : gi];
                    slot_age_next[gi]    = slot_age_reg[(gi < QUEUE_DEPTH - 1) ? gi + 1 : gi];
                    slot_handle_next[gi] =
                        slot_handle_reg[(gi < QUEUE_DEPTH - 1) ? gi + 1 : gi];
                end
            end

            always_ff @(posedge clk)
            begin
                if (cmd.execute)
                begin
                    slot_prio_reg[gi]   <= slot_prio_next[gi];
                    slot_age_reg[gi]    <= slot_age_next[gi];
                    slot_handle_reg[gi] <= slot_handle_next[gi];
                end
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (do_enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        if (mode_reg == spq_pkg::MODE_ENQUEUE)
        begin
            status_next = full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_ENQUEUED;
        end
        else
        begin
            status_next = empty ? spq_pkg::STATUS_EMPTY : spq_pkg::STATUS_DEQUEUED;
        end
    end

    // fill level wraps modulo 32 for deep queues
    assign count_ext = 32'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg     <= status_next;
            out_age_reg    <= do_deq ? slot_age_reg[0] : '0;
            out_handle_reg <= do_deq ? slot_handle_reg[0] : '0;
            out_prio_reg   <= do_deq ? slot_prio_reg[0] : '0;
            fill_reg       <= count_ext[spq_pkg::FILL_W-1:0];
        end
    end

    assign m_tuser = status_reg;
    assign m_tdata = {3'b000, fill_reg, out_prio_reg, out_handle_reg, out_age_reg};

    property p_count_bounded;
        @(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(QUEUE_DEPTH);
    endproperty
    a_count_bounded: assert property (p_count_bounded)
        else $error("entry count exceeds queue depth");

endmodule

>>> rtl/core/stable_priority_queue_core.sv
// Stable priority queue, sorted shift-register form.
// Input channel s_*: one request per handshake. s_tuser selects enqueue (0)
// or dequeue (1); s_tdata carries priority, age and record handle.
// Output channel m_*: one result per request. m_tuser carries the status
// (enqueued, dequeued, empty, or full when refused); m_tdata carries the removed
// entry's age, handle and priority (zero unless dequeued) and the fill level.
// Each request is captured in the accept cycle and applied to all slots at
// once in the next cycle by the per-slot compare and shift logic, which also
// loads the result register; the result then stays valid until it is taken.
// The capture / execute sequencer takes no new request until the current one
// has executed.
// A lower priority value leaves first; equal priorities leave in arrival order.
// Reset empties the queue (slot contents stay undefined) and drops any
// pending result. While a result waits on a stalled receiver, no new request
// is taken; the request taken in the cycle the result leaves overlaps it.
module stable_priority_queue_core
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [7:0] priority_req, [15:8] age, [31:16] record_handle
    input  logic [spq_pkg::IN_W-1:0]   s_tdata,
    // [0] mode
    input  logic                       s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [7:0] out_age, [23:8] out_handle, [31:24] out_priority,
    // [36:32] fill_level, [39:37] zero
    output logic [spq_pkg::OUT_W-1:0]  m_tdata,
    // [1:0] status
    output logic [1:0]                 m_tuser
);

    spq_pkg::ctrl_cmd_t cmd;

    // sequence capture and execute, hold the result valid until taken
    spq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // slots, entry count and result register
    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // an accepted request never finds a result still pending in the next cycle
    a_accept_clears_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result pending when request executes");

    // a stalled result blocks new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("request taken while result stalled");

    // every executed request yields a result
    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> m_tvalid)
        else $error("executed request produced no result");

    // capture and execute never overlap
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.execute))
        else $error("capture and execute in the same cycle");

endmodule

>>> dv/spq_scoreboard_pkg.sv
package spq_scoreboard_pkg;

    import spq_pkg::*;

    typedef struct {
        logic [PRIO_W-1:0]   prio;
        logic [AGE_W-1:0]    age;
        logic [HANDLE_W-1:0] handle;
    } queue_slot_t;

    typedef struct {
        status_t             status;
        logic [AGE_W-1:0]    age;
        logic [HANDLE_W-1:0] handle;
        logic [PRIO_W-1:0]   prio;
        logic [FILL_W-1:0]   fill;
    } queue_outcome_t;

    class spq_order_scoreboard;
        int             depth;
        queue_slot_t    slots[$];
        queue_outcome_t awaited[$];
        int             mismatches;
        int             results_checked;
        int             status_seen[4];
        int             peak_fill;

        function new(int depth);
            this.depth = depth;
            mismatches = 0;
            results_checked = 0;
            peak_fill = 0;
            foreach (status_seen[k])
                status_seen[k] = 0;
        endfunction

        // Apply one accepted request to the shadow queue and record its outcome.
        function void note_request(logic mode, logic [IN_W-1:0] data);
            queue_slot_t    entry;
            queue_slot_t    head;
            queue_outcome_t outcome;
            int             pos;
            entry.prio   = data[7:0];
            entry.age    = data[15:8];
            entry.handle = data[31:16];
            outcome.status = STATUS_ENQUEUED;
            outcome.age    = '0;
            outcome.handle = '0;
            outcome.prio   = '0;
            if (mode == MODE_ENQUEUE) begin
                if (slots.size() >= depth) begin
                    outcome.status = STATUS_FULL;
                end
                else begin
                    // go behind every stored entry of equal or lower value
                    pos = 0;
                    while (pos < slots.size() && slots[pos].prio <= entry.prio)
                        pos++;
                    slots.insert(pos, entry);
                end
            end
            else if (slots.size() == 0) begin
                outcome.status = STATUS_EMPTY;
            end
            else begin
                head = slots.pop_front();
                outcome.status = STATUS_DEQUEUED;
                outcome.age    = head.age;
                outcome.handle = head.handle;
                outcome.prio   = head.prio;
            end
            outcome.fill = FILL_W'(slots.size());
            if (slots.size() > peak_fill)
                peak_fill = slots.size();
            awaited.push_back(outcome);
        endfunction

        function void compare_field(string name, logic [31:0] expv, logic [31:0] actv);
            if (actv !== expv) begin
                $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
                mismatches++;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] data, logic [1:0] user);
            queue_outcome_t outcome;
            if (awaited.size() == 0) begin
                $error("result with no request waiting: status %0d", user);
                mismatches++;
                return;
            end
            outcome = awaited.pop_front();
            results_checked++;
            status_seen[outcome.status]++;
            compare_field("status", 32'(outcome.status), 32'(user));
            compare_field("out_age", 32'(outcome.age), 32'(data[7:0]));
            compare_field("out_handle", 32'(outcome.handle), 32'(data[23:8]));
            compare_field("out_priority", 32'(outcome.prio), 32'(data[31:24]));
            compare_field("fill_level", 32'(outcome.fill), 32'(data[36:32]));
            compare_field("pad", 32'd0, 32'(data[39:37]));
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void flush_report();
            foreach (awaited[k]) begin
                $error("request left without result: status %0d expected",
                       awaited[k].status);
                mismatches++;
            end
        endfunction
    endclass

endpackage

>>> dv/stable_priority_queue_core_tb.sv
module stable_priority_queue_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;
    import spq_scoreboard_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1826;
    localparam int QUIET_TAIL   = 250;     // final requests with no idling on either side
    localparam int PHASE_LEN    = 60;      // requests per enqueue/dequeue bias phase
    localparam int HOLD_AT      = 600;     // results seen before the long receiver hold
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT  = 5000;
    // ~1850 requests, each with at worst one idle gap, one receiver stall and the
    // capture / execute sequence, plus the hold; the limit allows a wide margin
    localparam int CYCLE_LIMIT  = 400000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;   // [7:0] priority_req, [15:8] age, [31:16] record_handle
    logic              s_tuser = MODE_ENQUEUE;   // [0] mode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;        // [7:0] age, [23:8] handle, [31:24] priority, [36:32] fill
    logic [1:0]        m_tuser;        // [1:0] status

    spq_order_scoreboard board;

    // Idling switches, flipped per phase by the stimulus thread
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_done  = 1'b0;
    int cycles;

    stable_priority_queue_core #(.QUEUE_DEPTH(DEPTH)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Watchdog: end the run if the cycle budget runs out
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
    end

    // Sample both handshakes with pre-edge values. Check the result first so a
    // stray result can never pair with a request accepted at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                board.note_request(s_tuser, s_tdata);
        end
    end

    // Receiver: random ready/stall bursts, plus one long hold that backs up
    // the queue core until it drops s_tready while the sender keeps offering.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (!hold_done && board.results_checked >= HOLD_AT)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Offer one request and hold it until the core takes it. An optional idle
    // burst goes in front; s_tvalid gets one assignment per time step.
    task automatic send_request(input logic mode, input logic [7:0] prio,
                                input logic [7:0] age, input logic [15:0] handle);
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {handle, age, prio};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Random request under the current enqueue bias. Half the priorities come
    // from a four-value set so ties (and the arrival-order rule) are common.
    task automatic send_random_request(input int enq_pct);
        logic       mode;
        logic [7:0] prio;
        mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQUEUE : MODE_DEQUEUE;
        if ($urandom_range(0, 1) == 0)
            prio = 8'($urandom_range(0, 3) * 85);
        else
            prio = 8'($urandom);
        send_request(mode, prio, 8'($urandom), 16'($urandom));
    endtask

    initial
    begin
        int i;
        int enq_pct;
        int waited;
        board = new(DEPTH);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: dequeue on empty
        send_request(MODE_DEQUEUE, 8'h00, 8'h00, 16'h0000);
        // Field extremes and ties at the middle, the minimum and the maximum
        send_request(MODE_ENQUEUE, 8'd128, 8'h00, 16'h0000);
        send_request(MODE_ENQUEUE, 8'd128, 8'hFF, 16'hFFFF);
        send_request(MODE_ENQUEUE, 8'd255, 8'hAA, 16'h5555);
        send_request(MODE_ENQUEUE, 8'd0,   8'h01, 16'h0001);
        send_request(MODE_ENQUEUE, 8'd255, 8'h55, 16'hAAAA);
        send_request(MODE_ENQUEUE, 8'd0,   8'hFF, 16'h8000);
        send_request(MODE_ENQUEUE, 8'd128, 8'h7F, 16'h7FFF);
        // Fill the remaining slots with a spread of values and one more tie at priority 0
        for (i = 0; i < 9; i++)
            send_request(MODE_ENQUEUE, 8'(i * 30), 8'(i), 16'(16'h1000 + i));
        // Queue full: refuse both a middle and the most urgent priority
        send_request(MODE_ENQUEUE, 8'd64, 8'h12, 16'h3456);
        send_request(MODE_ENQUEUE, 8'd0,  8'h34, 16'h789A);
        // Pull a few heads; the rest drain in the random part
        for (i = 0; i < 5; i++)
            send_request(MODE_DEQUEUE, 8'hFF, 8'hFF, 16'hFFFF);

        // Random: phases swing between fill-heavy, balanced and drain-heavy
        enq_pct = 50;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % PHASE_LEN == 0)
            begin
                case ($urandom_range(0, 2))
                    0: enq_pct = 80;
                    1: enq_pct = 50;
                    default: enq_pct = 20;
                endcase
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (i >= RANDOM_ITEMS - QUIET_TAIL)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            send_random_request(enq_pct);
        end
        s_tvalid <= 1'b0;

        // Drain, then let the pipeline settle to catch any extra result
        waited = 0;
        while (board.outstanding() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        board.flush_report();

        $display("Checked %0d results: %0d enqueued, %0d dequeued, %0d empty, %0d refused",
                 board.results_checked, board.status_seen[STATUS_ENQUEUED],
                 board.status_seen[STATUS_DEQUEUED], board.status_seen[STATUS_EMPTY],
                 board.status_seen[STATUS_FULL]);
        $display("Peak fill %0d of %0d, long receiver hold %s, %0d mismatches",
                 board.peak_fill, DEPTH, hold_done ? "done" : "not reached",
                 board.mismatches);
        if (board.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
